// ----- sv/memory_region_range_checker_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Memory region range checker assertion macros
// Shorthand for the clocked assertions of the checker, reset-qualified but for one.
// ---------------------------------------------------------------------------
`ifndef MEMORY_REGION_RANGE_CHECKER_UNIT_MACROS_SVH
`define MEMORY_REGION_RANGE_CHECKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MRRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrrc check failed");

// Next-cycle implication, disabled while reset is high.
`define MRRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrrc check failed");

// Next-cycle implication that also holds across reset.
`define MRRC_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mrrc check failed");

`endif

// ----- sv/mrrc_pkg.sv -----
// ---------------------------------------------------------------------------
// Memory region range checker package
// Shared widths, codes, controller states and command/status bundles.
// ---------------------------------------------------------------------------
package mrrc_pkg;

  localparam int MAX_REGIONS_DEF    = 16;
  localparam int PAGE_SIZE_LOG2_DEF = 12;

  localparam int ADDR_W  = 64;
  localparam int PAGES_W = 60;
  localparam int TYPE_W  = 3;
  localparam int IDX_W   = 4;
  localparam int COUNT_W = 5;

  localparam int IN_TDATA_W  = 264;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_REGION_COUNT  = 1'b0,
    REG_RESERVED_TYPE = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DECIDE,
    ST_OVL_ADDR,
    ST_OVL_END,
    ST_OVL_TEST,
    ST_COV_START,
    ST_COV_ADDR,
    ST_COV_END,
    ST_COV_TEST,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // write the table entry carried by the input item
    logic capture;   // register the query fields
    logic setup;     // form the query end, clear results and the walk
    logic entry;     // register the entry read from the table
    logic ovl_test;  // record an overlap hit
    logic cov_test;  // advance the coverage position on a hit
    logic idx_clr;
    logic idx_inc;
    logic wrap_res;  // report the reserved type for a wrapping query
    logic push;      // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_zero;
    logic q_wrap;
    logic q_zero;
    logic last;
    logic ovl_hit;
    logic cov_hit;
    logic cov_done;
    logic out_free;
  } status_t;

  function automatic logic is_normal(input logic [TYPE_W-1:0] t);
    return (t == 3'd0) || (t == 3'd1);
  endfunction

endpackage

// ----- sv/mrrc_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module mrrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/mrrc_ctrl.sv -----
// ---------------------------------------------------------------------------
// Memory region range checker controller
// Sequences the overlap scan and the coverage walk over the region table.
// ---------------------------------------------------------------------------
module mrrc_ctrl
  import mrrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    s_req_type,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && (req_t'(s_req_type) == REQ_QUERY)) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP:  state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (status.n_zero || status.q_wrap) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_OVL_ADDR;
        end
      end
      ST_OVL_ADDR: state_next = ST_OVL_END;
      ST_OVL_END:  state_next = ST_OVL_TEST;
      ST_OVL_TEST: begin
        if (status.ovl_hit || status.last) begin
          state_next = ST_COV_START;
        end else begin
          state_next = ST_OVL_ADDR;
        end
      end
      ST_COV_START: begin
        if (status.q_zero) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_COV_ADDR;
        end
      end
      ST_COV_ADDR: state_next = ST_COV_END;
      ST_COV_END:  state_next = ST_COV_TEST;
      ST_COV_TEST: begin
        priority if (status.cov_hit && status.cov_done) begin
          state_next = ST_FINISH;
        end else if (status.cov_hit) begin
          state_next = ST_COV_ADDR;
        end else if (status.last) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_COV_ADDR;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load    = (req_t'(s_req_type) == REQ_LOAD);
          cmd.capture = (req_t'(s_req_type) == REQ_QUERY);
        end
      end
      ST_SETUP: cmd.setup = 1'b1;
      ST_DECIDE: begin
        cmd.wrap_res = !status.n_zero && status.q_wrap;
      end
      ST_OVL_ADDR: ;
      ST_OVL_END:  cmd.entry = 1'b1;
      ST_OVL_TEST: begin
        cmd.ovl_test = 1'b1;
        cmd.idx_inc  = !status.ovl_hit && !status.last;
      end
      ST_COV_START: cmd.idx_clr = 1'b1;
      ST_COV_ADDR:  ;
      ST_COV_END:   cmd.entry = 1'b1;
      ST_COV_TEST: begin
        cmd.cov_test = 1'b1;
        cmd.idx_clr  = status.cov_hit && !status.cov_done;
        cmd.idx_inc  = !status.cov_hit && !status.last;
      end
      ST_FINISH: cmd.push = status.out_free;
      default: ;
    endcase
  end

endmodule

// ----- sv/mrrc_dp.sv -----
// ---------------------------------------------------------------------------
// Memory region range checker datapath
// Region table, configuration, query registers, entry compares and output.
// ---------------------------------------------------------------------------
module mrrc_dp
  import mrrc_pkg::*;
#(
  parameter int MAX_REGIONS    = MAX_REGIONS_DEF,
  parameter int PAGE_SIZE_LOG2 = PAGE_SIZE_LOG2_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic [IDX_W-1:0]       entry_index,
  input  logic [ADDR_W-1:0]      region_start,
  input  logic [PAGES_W-1:0]     region_pages,
  input  logic [TYPE_W-1:0]      region_type,
  input  logic [ADDR_W-1:0]      query_start,
  input  logic [ADDR_W-1:0]      query_size,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   in_normal,
  output logic                   overlap_found,
  output logic [TYPE_W-1:0]      overlap_type
);

  localparam int AW      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W   = $clog2(MAX_REGIONS + 1);
  localparam int CW      = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int ENTRY_W = ADDR_W + PAGES_W + TYPE_W;

  // Configuration registers.
  logic [COUNT_W-1:0] region_count;
  logic [TYPE_W-1:0]  reserved_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_count  <= '0;
      reserved_type <= 3'd4;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REGION_COUNT:  region_count  <= cfg_wdata[COUNT_W-1:0];
        REG_RESERVED_TYPE: reserved_type <= cfg_wdata[TYPE_W-1:0];
      endcase
    end
  end

  logic [CW-1:0] count_ext;
  logic [CW-1:0] n_act;
  assign count_ext = CW'(region_count);
  assign n_act     = (count_ext > CW'(MAX_REGIONS)) ? CW'(MAX_REGIONS) : count_ext;

  // Region table. Loads to slots beyond the table are dropped.
  logic [AW-1:0]      idx;
  logic               tbl_we;
  logic [ENTRY_W-1:0] tbl_rdata;

  assign tbl_we = cmd.load && (CW'(entry_index) < CW'(MAX_REGIONS));

  mrrc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_REGIONS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(entry_index)),
    .wdata ({region_type, region_pages, region_start}),
    .raddr (idx),
    .rdata (tbl_rdata)
  );

  // Query registers.
  logic [ADDR_W-1:0] q_start;
  logic [ADDR_W-1:0] q_size;
  logic [ADDR_W-1:0] q_end;
  logic              q_wrap;
  logic              q_zero;
  logic [ADDR_W:0]   q_sum;

  assign q_sum = {1'b0, q_start} + {1'b0, q_size};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_start <= query_start;
      q_size  <= query_size;
    end
    if (cmd.setup) begin
      q_end  <= q_sum[ADDR_W-1:0];
      q_wrap <= q_sum[ADDR_W];
      q_zero <= (q_size == '0);
    end
  end

  // Entry stage: region end and malformed flag.
  logic [ADDR_W-1:0]  rd_start;
  logic [PAGES_W-1:0] rd_pages;
  logic [TYPE_W-1:0]  rd_type;
  logic               rd_pages_ovf;
  logic [ADDR_W-1:0]  rd_size;
  logic [ADDR_W:0]    rd_sum;

  assign rd_start     = tbl_rdata[ADDR_W-1:0];
  assign rd_pages     = tbl_rdata[ADDR_W +: PAGES_W];
  assign rd_type      = tbl_rdata[ADDR_W+PAGES_W +: TYPE_W];
  assign rd_pages_ovf = |(rd_pages >> (ADDR_W - PAGE_SIZE_LOG2));
  assign rd_size      = ADDR_W'({rd_pages, {PAGE_SIZE_LOG2{1'b0}}});
  assign rd_sum       = {1'b0, rd_start} + {1'b0, rd_size};

  logic [ADDR_W-1:0] e_start;
  logic [ADDR_W-1:0] e_end;
  logic              e_bad;
  logic [TYPE_W-1:0] e_type;

  always_ff @(posedge clk) begin
    if (cmd.entry) begin
      e_start <= rd_start;
      e_end   <= rd_sum[ADDR_W-1:0];
      e_bad   <= rd_pages_ovf || rd_sum[ADDR_W];
      e_type  <= rd_type;
    end
  end

  // Compare stage.
  logic [ADDR_W-1:0] pos;
  logic              ovl_hit;
  logic              cov_hit;
  logic              cov_done;

  assign ovl_hit  = !is_normal(e_type) &&
                    (e_bad || ((q_start < e_end) && (q_end > e_start)));
  assign cov_hit  = is_normal(e_type) && !e_bad && (pos >= e_start) && (pos < e_end);
  assign cov_done = (e_end >= q_end);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      pos <= q_start;
    end else if (cmd.cov_test && cov_hit) begin
      pos <= cov_done ? q_end : e_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.setup || cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end
  end

  // Working result.
  logic              res_normal;
  logic              res_found;
  logic [TYPE_W-1:0] res_type;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      res_normal <= 1'b0;
      res_found  <= 1'b0;
      res_type   <= '0;
    end else begin
      if (cmd.wrap_res) begin
        res_found <= 1'b1;
        res_type  <= reserved_type;
      end
      if (cmd.ovl_test && ovl_hit) begin
        res_found <= 1'b1;
        res_type  <= e_type;
      end
      if (cmd.cov_test && cov_hit && cov_done) begin
        res_normal <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      in_normal     <= res_normal;
      overlap_found <= res_found;
      overlap_type  <= res_type;
    end
  end

  assign status.n_zero   = (n_act == '0);
  assign status.q_wrap   = q_wrap;
  assign status.q_zero   = q_zero;
  assign status.last     = ((CW'(idx) + CW'(1)) == n_act);
  assign status.ovl_hit  = ovl_hit;
  assign status.cov_hit  = cov_hit;
  assign status.cov_done = cov_done;
  assign status.out_free = !out_valid || out_ready;

endmodule

// ----- sv/memory_region_range_checker_unit.sv -----
// ---------------------------------------------------------------------------
// Memory region range checker unit
// Region table with range coverage and non-normal overlap queries.
// ---------------------------------------------------------------------------
// The unit keeps a table of up to MAX_REGIONS memory regions, each a start
// address, a length in pages of 2**PAGE_SIZE_LOG2 bytes and a type code
// (types 0 and 1 are normal memory). A load item (tuser = 0) writes one
// table slot and gives no result. A query item (tuser = 1) gives one
// result item: whether the byte range lies wholly in normal regions, and
// the type of the first non-normal region in table order that touches the
// range or is malformed. The table is a single-port-read RAM, and every
// table entry the query looks at takes three steps (address, end
// computation, compare). A query first scans up to n = min(region_count,
// MAX_REGIONS) entries for an overlap, stopping at the first hit, then walks
// the coverage, restarting the scan at entry 0 each time it moves into the
// next region. The entries read number at most n for the overlap scan and
// at most n*(n+1) for the coverage walk. When entries 0 to k-1 carry the
// range in table order, the walk reads k*(k+1)/2 entries. A zero-size
// query skips the walk. A query on an empty table or with a wrapping range
// skips both passes. One query is worked on at a time; a finished result
// sits in an output register, so the next item can be taken in the cycle
// after the result is loaded, while that result waits. A query that
// finishes while the previous result still waits holds until the output
// register frees. The user must write configuration only while the unit is
// idle; the unit does not enforce this. Table slots are undefined until
// loaded, and the table needs no clearing after reset.
module memory_region_range_checker_unit
  import mrrc_pkg::*;
#(
  parameter int MAX_REGIONS    = MAX_REGIONS_DEF,
  parameter int PAGE_SIZE_LOG2 = PAGE_SIZE_LOG2_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input items.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // entry_index[3:0], region_start[67:4], region_pages[127:68],
  // region_type[130:128], query_start[194:131], query_size[258:195], zero fill
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // req_type[0]
  input  logic                   s_tuser,
  // Result items.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // in_normal[0], overlap_found[1], overlap_type[4:2], zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // Configuration writes.
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // Unpack the input item.
  logic [IDX_W-1:0]   entry_index;
  logic [ADDR_W-1:0]  region_start;
  logic [PAGES_W-1:0] region_pages;
  logic [TYPE_W-1:0]  region_type;
  logic [ADDR_W-1:0]  query_start;
  logic [ADDR_W-1:0]  query_size;

  assign entry_index  = s_tdata[3:0];
  assign region_start = s_tdata[67:4];
  assign region_pages = s_tdata[127:68];
  assign region_type  = s_tdata[130:128];
  assign query_start  = s_tdata[194:131];
  assign query_size   = s_tdata[258:195];

  cmd_t    cmd;
  status_t status;

  logic              in_normal;
  logic              overlap_found;
  logic [TYPE_W-1:0] overlap_type;

  // The controller owns the sequence; the datapath owns all data storage.
  mrrc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_req_type (s_tuser),
    .s_tready   (s_tready),
    .status     (status),
    .cmd        (cmd)
  );

  mrrc_dp #(
    .MAX_REGIONS    (MAX_REGIONS),
    .PAGE_SIZE_LOG2 (PAGE_SIZE_LOG2)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .entry_index   (entry_index),
    .region_start  (region_start),
    .region_pages  (region_pages),
    .region_type   (region_type),
    .query_start   (query_start),
    .query_size    (query_size),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .in_normal     (in_normal),
    .overlap_found (overlap_found),
    .overlap_type  (overlap_type)
  );

  // Pack the result item; the upper bits are zero fill.
  assign m_tdata = {3'b000, overlap_type, overlap_found, in_normal};

endmodule

// ----- sv/mrrc_checker.sv -----
// ---------------------------------------------------------------------------
// Memory region range checker port checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "memory_region_range_checker_unit_macros.svh"

module mrrc_checker
  import mrrc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result keeps its value.
  `MRRC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // The type field is zero whenever no overlap is reported.
  `MRRC_ASSERT_NOW(a_type_zero, m_tvalid && !m_tdata[1], m_tdata[4:2] == 3'd0)

  // Once a query is taken the unit is busy with it in the next cycle.
  `MRRC_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && s_tuser, !s_tready)

  // No result is shown right after reset.
  `MRRC_ASSERT_ALWAYS(a_reset_quiet, rst, !m_tvalid)

endmodule

bind memory_region_range_checker_unit mrrc_checker u_mrrc_checker (.*);
